/* rtl/aabb_collision_axis_macros.svh */
// assertion helpers for the rtl of the box collision axis block
`ifndef AABB_COLLISION_AXIS_MACROS_SVH
`define AABB_COLLISION_AXIS_MACROS_SVH

// same-cycle implication under synchronous reset
`define AABB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define AABB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define AABB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and codes of the box collision axis block
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

  localparam int NUM_AXES = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // result word, hit in the lowest bit
  typedef struct packed {
    logic       push_positive;
    logic [1:0] axis;
    logic       hit;
  } result_t;

  localparam int RESULT_BITS  = $bits(result_t);
  localparam int OUT_TDATA_W  = ((RESULT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/aabb_collision_axis.sv */
// ----------------------------------------------------------------------------
// aabb_collision_axis
// collision test and least-penetration axis for two axis-aligned 3-d boxes
// ----------------------------------------------------------------------------
// One box pair per transfer, one result per pair, in order. The block is a
// four-stage pipeline (doubled faces, face differences, per-axis push,
// axis select) that takes a new pair every cycle while the output side is
// not stalled; each pair passes through the stage registers in that order.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up and nothing is dropped. There is no state between pairs.
`default_nettype none

`include "aabb_collision_axis_macros.svh"

module aabb_collision_axis #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // self_pos_x, self_pos_y, self_pos_z, self_size_x, self_size_y, self_size_z,
  // other_pos_x, other_pos_y, other_pos_z, other_size_x, other_size_y,
  // other_size_z, zero fill
  input  wire logic [((12*COORD_WIDTH-6+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // hit, axis[1:0], push_positive, zero fill
  output logic [aabb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import aabb_pkg::*;

  localparam int PW = COORD_WIDTH;        // position width
  localparam int SW = COORD_WIDTH - 1;    // size width
  localparam int FW = COORD_WIDTH + 2;    // doubled face width
  localparam int DW = COORD_WIDTH + 3;    // face difference width
  localparam int MW = COORD_WIDTH + 2;    // push magnitude width
  localparam int OFS_SP = 0;
  localparam int OFS_SS = 3 * PW;
  localparam int OFS_OP = 3 * PW + 3 * SW;
  localparam int OFS_OS = 6 * PW + 3 * SW;

  // stage handshakes
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // per-axis datapath, stages 1 to 3
  logic signed [FW-1:0] s_lo_r [NUM_AXES];
  logic signed [FW-1:0] s_hi_r [NUM_AXES];
  logic signed [FW-1:0] o_lo_r [NUM_AXES];
  logic signed [FW-1:0] o_hi_r [NUM_AXES];
  logic signed [DW-1:0] to_low_r  [NUM_AXES];
  logic signed [DW-1:0] to_high_r [NUM_AXES];
  logic [MW-1:0]        mag_r [NUM_AXES];
  logic [NUM_AXES-1:0]  pos_r;
  logic [NUM_AXES-1:0]  nz_r;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic [PW-1:0] sp, op;
    logic [SW-1:0] ss, os;
    logic signed [FW-1:0] sp2, op2, ssx, osx;
    logic signed [FW-1:0] s_lo_nxt, s_hi_nxt, o_lo_nxt, o_hi_nxt;
    logic signed [DW-1:0] to_low_nxt, to_high_nxt;
    logic          ok, lt;
    logic [MW-1:0] mag_nxt;

    assign sp = in_tdata[OFS_SP + a*PW +: PW];
    assign ss = in_tdata[OFS_SS + a*SW +: SW];
    assign op = in_tdata[OFS_OP + a*PW +: PW];
    assign os = in_tdata[OFS_OS + a*SW +: SW];

    // doubled coordinates: centre * 2 -/+ full size
    assign sp2 = $signed({sp[PW-1], sp, 1'b0});
    assign op2 = $signed({op[PW-1], op, 1'b0});
    assign ssx = $signed({3'b000, ss});
    assign osx = $signed({3'b000, os});
    assign s_lo_nxt = sp2 - ssx;
    assign s_hi_nxt = sp2 + ssx;
    assign o_lo_nxt = op2 - osx;
    assign o_hi_nxt = op2 + osx;

    assign to_low_nxt  = DW'(s_hi_r[a]) - DW'(o_lo_r[a]);
    assign to_high_nxt = DW'(o_hi_r[a]) - DW'(s_lo_r[a]);

    // overlap when both differences are non-negative
    assign ok = !to_low_r[a][DW-1] && !to_high_r[a][DW-1];
    assign lt = to_low_r[a] < to_high_r[a];
    assign mag_nxt = lt ? to_low_r[a][MW-1:0] : to_high_r[a][MW-1:0];

    always_ff @(posedge clk) begin
      if (en1) begin
        s_lo_r[a] <= s_lo_nxt;
        s_hi_r[a] <= s_hi_nxt;
        o_lo_r[a] <= o_lo_nxt;
        o_hi_r[a] <= o_hi_nxt;
      end
      if (en2) begin
        to_low_r[a]  <= to_low_nxt;
        to_high_r[a] <= to_high_nxt;
      end
      if (en3) begin
        mag_r[a] <= mag_nxt;
        pos_r[a] <= !lt;
        nz_r[a]  <= ok && (mag_nxt != '0);
      end
    end
  end

  // stage 4: least magnitude, lowest axis on a tie
  result_t res_r, res_nxt;
  logic [1:0]    best;
  logic [MW-1:0] best_mag;
  logic          best_pos;

  always_comb begin
    best     = AXIS_X;
    best_mag = mag_r[0];
    best_pos = pos_r[0];
    if (mag_r[1] < best_mag) begin
      best     = AXIS_Y;
      best_mag = mag_r[1];
      best_pos = pos_r[1];
    end
    if (mag_r[2] < best_mag) begin
      best     = AXIS_Z;
      best_pos = pos_r[2];
    end
    res_nxt = '0;
    if (&nz_r) begin
      res_nxt.hit           = 1'b1;
      res_nxt.axis          = best;
      res_nxt.push_positive = best_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) res_r <= res_nxt;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

  `AABB_ASSERT_SAME(a_miss_clears_fields, clk, rst_n, out_tvalid && !res_r.hit, res_r.axis == AXIS_X && !res_r.push_positive, "miss result carries nonzero axis or sign")
  `AABB_ASSERT_SAME(a_axis_code, clk, rst_n, out_tvalid, res_r.axis != 2'd3, "axis code out of range")
  `AABB_ASSERT_NEXT(a_take_fills_stage1, clk, rst_n, in_tvalid && in_tready, v1_r, "accepted pair did not enter the first stage")
  `AABB_ASSERT_ALWAYS_NEXT(a_reset_empties, clk, !rst_n, !out_tvalid && !v1_r, "pipeline not empty after reset")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the box collision axis block
// ----------------------------------------------------------------------------
// Box pairs go in as stream transfers. Each accepted pair is run through a
// local predictor of the per-axis push depths and the least-push axis
// selection. Every result transfer is compared field by field with the oldest
// pending prediction. The run starts with hand-picked geometry: extremes,
// touching faces, equal pushes and axis ties. It then sends random pairs,
// mostly overlapping boxes plus raw noise, under four idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  localparam int CW             = 24;
  localparam int PAIR_BITS      = 12 * CW - 6;
  localparam int IN_W           = ((PAIR_BITS + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_PAIRS    = 385;
  localparam longint MAX_POS    = (longint'(1) << (CW - 1)) - 1;
  localparam longint MIN_POS    = -(longint'(1) << (CW - 1));
  localparam longint MAX_SIZE   = (longint'(1) << (CW - 1)) - 1;

  // lowest bits first: self pos x/y/z, self size x/y/z, other pos, other size
  typedef struct packed {
    logic [2:0][CW-2:0] osize;
    logic [2:0][CW-1:0] opos;
    logic [2:0][CW-2:0] ssize;
    logic [2:0][CW-1:0] spos;
  } pair_t;

  class collision_scoreboard;
    result_t     expected_q[$];
    int unsigned n_pairs;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_hits;
    int unsigned n_positive;
    int unsigned axis_hits[3];

    // signed push along one axis in doubled coordinates, 0 when apart
    static function longint push_depth(longint sp, longint ss, longint op, longint os);
      longint s_lo, s_hi, o_lo, o_hi, to_low, to_high;
      s_lo = 2 * sp - ss;
      s_hi = 2 * sp + ss;
      o_lo = 2 * op - os;
      o_hi = 2 * op + os;
      if (s_hi < o_lo || s_lo > o_hi) return 0;
      to_low  = s_hi - o_lo;
      to_high = o_hi - s_lo;
      return (to_low < to_high) ? -to_low : to_high;
    endfunction

    static function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    static function result_t collide(pair_t p);
      longint     depth[3];
      logic       all_in;
      logic [1:0] best;
      result_t    r;
      all_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
        depth[a] = push_depth(longint'($signed(p.spos[a])), longint'(p.ssize[a]),
                              longint'($signed(p.opos[a])), longint'(p.osize[a]));
        if (depth[a] == 0) all_in = 1'b0;
      end
      r = '0;
      if (!all_in) return r;
      best = AXIS_X;
      if (magnitude(depth[AXIS_Y]) < magnitude(depth[best])) best = AXIS_Y;
      if (magnitude(depth[AXIS_Z]) < magnitude(depth[best])) best = AXIS_Z;
      r.hit           = 1'b1;
      r.axis          = best;
      r.push_positive = (depth[best] > 0);
      return r;
    endfunction

    function void note_pair(logic [IN_W-1:0] word);
      pair_t   p;
      result_t r;
      p = word[PAIR_BITS-1:0];
      r = collide(p);
      expected_q.push_back(r);
      n_pairs++;
      if (r.hit) begin
        n_hits++;
        axis_hits[r.axis]++;
        if (r.push_positive) n_positive++;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      result_t got, want;
      got = word[RESULT_BITS-1:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual hit %0d axis %0d push_positive %0d",
                 $time, got.hit, got.axis, got.push_positive);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("axis", want.axis, got.axis);
      compare_field("push_positive", want.push_positive, got.push_positive);
    endfunction
  endclass

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned quiet_cycles  = 0;

  collision_scoreboard sb = new();

  aabb_collision_axis #(.COORD_WIDTH(CW)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pair(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still pending",
                 $time, quiet_cycles, sb.expected_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - PAIR_BITS){1'b0}}, p};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic pair_t uniform_pair(longint sp, longint ss, longint op, longint os);
    pair_t p;
    for (int a = 0; a < 3; a++) begin
      p.spos[a]  = sp[CW-1:0];
      p.ssize[a] = ss[CW-2:0];
      p.opos[a]  = op[CW-1:0];
      p.osize[a] = os[CW-2:0];
    end
    return p;
  endfunction

  function automatic longint rand_coord();
    logic [31:0] r;
    r = $urandom;
    return longint'($signed(r[CW-1:0]));
  endfunction

  function automatic pair_t rand_pair();
    pair_t         p;
    logic [IN_W-1:0] noise;
    longint        sp, ss, op, os, span, d;
    int unsigned   kind, scale;
    kind = $urandom_range(99);
    if (kind < 20) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      p = noise[PAIR_BITS-1:0];
      return p;
    end
    for (int a = 0; a < 3; a++) begin
      scale = $urandom_range(23, 1);
      ss    = $urandom_range((1 << scale) - 1);
      os    = $urandom_range((1 << scale) - 1);
      sp    = rand_coord();
      span  = ss + os;
      case ($urandom_range(9))
        0: begin
          // faces exactly touching needs an even span
          if (span[0]) begin
            os   = os ^ 1;
            span = ss + os;
          end
          d = $urandom_range(1) ? span : -span;
        end
        1: begin
          d = span + 2 + $urandom_range(1000);
          if ($urandom_range(1)) d = -d;
        end
        default: d = longint'($urandom_range(32'(2 * span))) - span;
      endcase
      op = sp + d / 2;
      if (op > MAX_POS) op = MAX_POS;
      if (op < MIN_POS) op = MIN_POS;
      p.spos[a]  = sp[CW-1:0];
      p.ssize[a] = ss[CW-2:0];
      p.opos[a]  = op[CW-1:0];
      p.osize[a] = os[CW-2:0];
    end
    // same geometry on every axis forces ties in the axis pick
    if (kind < 30) begin
      for (int a = 1; a < 3; a++) begin
        p.spos[a]  = p.spos[0];
        p.ssize[a] = p.ssize[0];
        p.opos[a]  = p.opos[0];
        p.osize[a] = p.osize[0];
      end
    end
    return p;
  endfunction

  task automatic directed_pairs();
    pair_t p;
    send_pair(uniform_pair(0, 0, 0, 0));
    send_pair(uniform_pair(0, 256, 0, 256));
    send_pair(uniform_pair(MAX_POS, MAX_SIZE, MAX_POS, MAX_SIZE));
    send_pair(uniform_pair(MIN_POS, MAX_SIZE, MIN_POS, MAX_SIZE));
    send_pair(uniform_pair(MAX_POS, MAX_SIZE, MIN_POS, MAX_SIZE));
    send_pair(uniform_pair(MIN_POS, 0, MAX_POS, 0));
    send_pair(uniform_pair(MAX_POS, 0, MAX_POS, 0));
    send_pair(uniform_pair(0, 2, 1, 1));
    for (int a = 0; a < 3; a++) begin
      // touching faces on one axis only
      p = uniform_pair(0, 512, 0, 512);
      p.opos[a] = 512;
      send_pair(p);
      // least push on this axis, toward the low face
      p = uniform_pair(0, 512, 0, 512);
      p.opos[a] = 100;
      send_pair(p);
      // least push on this axis, toward the high face
      p = uniform_pair(0, 512, 0, 512);
      p.opos[a] = -100;
      send_pair(p);
    end
    // y and z tie, x deeper
    p = uniform_pair(0, 512, 0, 512);
    p.opos[1] = 100;
    p.opos[2] = -100;
    send_pair(p);
    // x and z tie, y deeper
    p = uniform_pair(0, 512, 0, 512);
    p.opos[0] = -100;
    p.opos[2] = 100;
    send_pair(p);
    // point inside a huge box, nearest the low face on z
    p = uniform_pair(0, 0, 0, MAX_SIZE);
    p.spos[2] = -3;
    send_pair(p);
    // apart on y only
    p = uniform_pair(0, 512, 0, 512);
    p.opos[1] = 1000;
    send_pair(p);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_pairs();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 84; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 84; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      for (int i = 0; i < PHASE_PAIRS; i++) send_pair(rand_pair());
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d box pairs, %0d collisions (x %0d, y %0d, z %0d, %0d positive)",
             sb.n_pairs, sb.n_hits, sb.axis_hits[0], sb.axis_hits[1], sb.axis_hits[2],
             sb.n_positive);
    $display("flow mixes: free, sparse input, heavy output stall, mixed; %0d mismatches",
             sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_collision_axis.sv
tb/sv/tb_top.sv
